/* hw/rtl/lle_pkg.sv */
// Shared types, key codes and LCD command constants for the LCD line editor.
package lle_pkg;

  localparam int TEXT_DEPTH_DEF      = 80;
  localparam int ROW_LENGTH_DEF      = 40;
  localparam int VISIBLE_COLUMNS_DEF = 16;
  localparam int SECOND_ROW_BASE     = 64;

  localparam logic [7:0] KEY_BKSP   = 8'h08;
  localparam logic [7:0] KEY_ESC    = 8'h1b;
  localparam logic [7:0] KEY_LEFT   = 8'h5b;
  localparam logic [7:0] KEY_RIGHT  = 8'h5d;
  localparam logic [7:0] KEY_ENTER  = 8'h0d;

  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
  localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1c;
  localparam logic [7:0] CMD_ADDR_BASE   = 8'h80;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;

  typedef enum logic [1:0] {
    IK_KEY   = 2'd0,
    IK_CLEAR = 2'd1,
    IK_READ  = 2'd2,
    IK_NONE  = 2'd3
  } in_kind_t;

  typedef enum logic [1:0] {
    OK_LCD   = 2'd0,
    OK_ENTER = 2'd1,
    OK_READ  = 2'd2,
    OK_NONE  = 2'd3
  } out_kind_t;

  typedef enum logic [2:0] {
    KC_BKSP,
    KC_ESC,
    KC_LEFT,
    KC_RIGHT,
    KC_ENTER,
    KC_CHAR
  } key_cls_t;

  typedef enum logic [2:0] {
    EM_SHIFT,
    EM_ADDR,
    EM_SPACE,
    EM_CHAR,
    EM_ENTER,
    EM_CLEAR,
    EM_READ,
    EM_NONE
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHIFT,
    ST_ADDR_A,
    ST_SPACE,
    ST_ADDR_B,
    ST_CHAR,
    ST_ENTER,
    ST_CLEAR,
    ST_READ,
    ST_NONE
  } state_t;

  typedef struct packed {
    in_kind_t kind;
    key_cls_t cls;
    logic     move_ok;
    logic     shift_need;
    logic     esc_ok;
    logic     read_ok;
    logic     out_free;
  } lle_stat_t;

  typedef struct packed {
    logic  capture;
    logic  commit_move;
    logic  clear;
    logic  wr_en;
    logic  rd_en;
    logic  emit;
    emit_t sel;
    logic  last;
  } lle_cmd_t;

endpackage

/* hw/rtl/lle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/lle_ctrl.sv */
// Controller state machine that sequences the results (LCD bytes, enter, read or none) of one transaction.
module lle_ctrl
  import lle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lle_stat_t stat,
  output lle_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.sel         = EM_NONE;
    in_ready        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        unique case (stat.kind)
          IK_KEY: begin
            unique case (stat.cls)
              KC_BKSP, KC_LEFT, KC_RIGHT, KC_CHAR: begin
                if (stat.move_ok) begin
                  cmd.commit_move = 1'b1;
                  cmd.wr_en       = (stat.cls == KC_BKSP) || (stat.cls == KC_CHAR);
                  if (stat.shift_need) begin
                    state_nxt = ST_SHIFT;
                  end else if (stat.cls == KC_BKSP) begin
                    state_nxt = ST_ADDR_A;
                  end else if (stat.cls == KC_CHAR) begin
                    state_nxt = ST_CHAR;
                  end else begin
                    state_nxt = ST_ADDR_B;
                  end
                end else begin
                  state_nxt = ST_NONE;
                end
              end
              KC_ESC: begin
                if (stat.esc_ok) begin
                  cmd.wr_en = 1'b1;
                  state_nxt = ST_SPACE;
                end else begin
                  state_nxt = ST_NONE;
                end
              end
              KC_ENTER: state_nxt = ST_ENTER;
              default:  state_nxt = ST_NONE;
            endcase
          end
          IK_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = ST_CLEAR;
          end
          IK_READ: begin
            if (stat.read_ok) begin
              cmd.rd_en = 1'b1;
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_NONE;
            end
          end
          default: state_nxt = ST_NONE;
        endcase
      end
      ST_SHIFT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_SHIFT;
          if (stat.cls == KC_BKSP) begin
            state_nxt = ST_ADDR_A;
          end else if (stat.cls == KC_CHAR) begin
            state_nxt = ST_CHAR;
          end else begin
            state_nxt = ST_ADDR_B;
          end
        end
      end
      ST_ADDR_A: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_ADDR;
          state_nxt = ST_SPACE;
        end
      end
      ST_SPACE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_SPACE;
          state_nxt = ST_ADDR_B;
        end
      end
      ST_ADDR_B, ST_CHAR, ST_ENTER, ST_CLEAR, ST_READ, ST_NONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
          unique case (state_r)
            ST_ADDR_B: cmd.sel = EM_ADDR;
            ST_CHAR:   cmd.sel = EM_CHAR;
            ST_ENTER:  cmd.sel = EM_ENTER;
            ST_CLEAR:  cmd.sel = EM_CLEAR;
            ST_READ:   cmd.sel = EM_READ;
            default:   cmd.sel = EM_NONE;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over one not yet taken");

endmodule

/* hw/rtl/lle_datapath.sv */
// Datapath: cursor and window registers, text store and output register.
module lle_datapath
  import lle_pkg::*;
#(
  parameter int TEXT_DEPTH      = TEXT_DEPTH_DEF,
  parameter int ROW_LENGTH      = ROW_LENGTH_DEF,
  parameter int VISIBLE_COLUMNS = VISIBLE_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] in_data,
  input  logic [1:0]  in_kind,
  input  lle_cmd_t    cmd,
  output lle_stat_t   stat,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] out_data,
  output logic [2:0]  out_user,
  output logic        out_last
);

  localparam int CW      = $clog2(TEXT_DEPTH + 1);
  localparam int AW      = $clog2(TEXT_DEPTH);
  localparam int WMAX    = (TEXT_DEPTH > VISIBLE_COLUMNS) ? TEXT_DEPTH : VISIBLE_COLUMNS;
  localparam int WW      = $clog2(WMAX + 1);
  localparam int ROW_OFS = SECOND_ROW_BASE - ROW_LENGTH;

  logic [1:0]            kind_r;
  logic [7:0]            key_r;
  logic [6:0]            idx_r;
  logic [CW-1:0]         cursor_r;
  logic [WW-1:0]         win_right_r;
  logic [WW-1:0]         win_left_r;
  logic                  row_hi_r;
  logic                  shift_left_r;
  logic [TEXT_DEPTH-1:0] valid_r;
  logic                  rd_valid_r;
  logic                  out_valid_r;
  out_kind_t             out_kind_r;
  logic [7:0]            out_byte_r;
  logic                  out_is_data_r;
  logic [7:0]            out_rchar_r;
  logic                  out_last_r;

  key_cls_t      cls;
  logic          dec;
  logic [CW-1:0] new_pos;
  logic          move_ok;
  logic          sh_left;
  logic          sh_right;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    ram_rdata;
  logic [7:0]    addr_byte;

  always_comb begin
    unique case (key_r)
      KEY_BKSP:  cls = KC_BKSP;
      KEY_ESC:   cls = KC_ESC;
      KEY_LEFT:  cls = KC_LEFT;
      KEY_RIGHT: cls = KC_RIGHT;
      KEY_ENTER: cls = KC_ENTER;
      default:   cls = KC_CHAR;
    endcase
  end

  assign dec      = (cls == KC_BKSP) || (cls == KC_LEFT);
  assign new_pos  = dec ? (cursor_r - CW'(1)) : (cursor_r + CW'(1));
  assign move_ok  = dec ? (cursor_r != '0) : (cursor_r != CW'(TEXT_DEPTH));
  assign sh_left  = WW'(new_pos) > win_right_r;
  assign sh_right = WW'(new_pos) < win_left_r;

  assign wr_addr  = (cls == KC_BKSP) ? AW'(cursor_r - CW'(1)) : AW'(cursor_r);
  assign wr_data  = (cls == KC_CHAR) ? key_r : CHAR_SPACE;

  assign addr_byte = CMD_ADDR_BASE + 8'(cursor_r) + (row_hi_r ? 8'(ROW_OFS) : 8'd0);

  always_comb begin
    stat            = '0;
    stat.kind       = in_kind_t'(kind_r);
    stat.cls        = cls;
    stat.move_ok    = move_ok;
    stat.shift_need = sh_left || sh_right;
    stat.esc_ok     = cursor_r < CW'(TEXT_DEPTH);
    stat.read_ok    = {1'b0, idx_r} < 8'(TEXT_DEPTH);
    stat.out_free   = !out_valid_r || out_ready;
  end

  lle_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      key_r  <= in_data[7:0];
      idx_r  <= in_data[14:8];
    end
    if (cmd.commit_move) begin
      shift_left_r <= sh_left;
    end
    if (cmd.rd_en) begin
      rd_valid_r <= valid_r[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      win_right_r <= WW'(VISIBLE_COLUMNS - 1);
      win_left_r  <= '0;
      row_hi_r    <= 1'b0;
      valid_r     <= '0;
    end else begin
      if (cmd.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.clear) begin
        cursor_r    <= '0;
        win_right_r <= WW'(VISIBLE_COLUMNS - 1);
        win_left_r  <= '0;
      end else if (cmd.commit_move) begin
        cursor_r <= new_pos;
        row_hi_r <= 8'(new_pos) >= 8'(ROW_LENGTH);
        if (sh_left) begin
          win_right_r <= win_right_r + WW'(1);
          win_left_r  <= win_left_r + WW'(1);
        end else if (sh_right) begin
          win_right_r <= win_right_r - WW'(1);
          win_left_r  <= win_left_r - WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r    <= cmd.last;
      out_kind_r    <= OK_LCD;
      out_byte_r    <= 8'd0;
      out_is_data_r <= 1'b0;
      out_rchar_r   <= 8'd0;
      case (cmd.sel)
        EM_SHIFT: out_byte_r <= shift_left_r ? CMD_SHIFT_LEFT : CMD_SHIFT_RIGHT;
        EM_ADDR:  out_byte_r <= addr_byte;
        EM_SPACE: begin
          out_byte_r    <= CHAR_SPACE;
          out_is_data_r <= 1'b1;
        end
        EM_CHAR: begin
          out_byte_r    <= key_r;
          out_is_data_r <= 1'b1;
        end
        EM_ENTER: out_kind_r <= OK_ENTER;
        EM_CLEAR: out_byte_r <= CMD_CLEAR;
        EM_READ: begin
          out_kind_r  <= OK_READ;
          out_rchar_r <= rd_valid_r ? ram_rdata : 8'd0;
        end
        default: out_kind_r <= OK_NONE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {out_rchar_r, out_byte_r};
  assign out_user  = {out_is_data_r, out_kind_r};
  assign out_last  = out_last_r;

  a_cursor_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r <= CW'(TEXT_DEPTH)) && (WW'(cursor_r) >= win_left_r)
    && (WW'(cursor_r) <= win_right_r))
    else $error("cursor left its range or the visible window");

  a_window_width: assert property (@(posedge clk) disable iff (!rst_n)
    (win_right_r - win_left_r) == WW'(VISIBLE_COLUMNS - 1))
    else $error("visible window lost its width");

endmodule

/* hw/rtl/lcd_line_editor.sv */
// A transaction's first result is loaded into the output register after the controller
// has left its decide state. Each transaction yields one to four results, one per
// cycle while out_tready is high. No new input is taken while results of the last
// remain to be loaded; the next is taken as soon as the final result sits in the output
// register. Reset (synchronous, rst_n low) clears the cursor and window; per-entry valid
// flags make the whole text store read as zero at once, with no clearing pass.
module lcd_line_editor
  import lle_pkg::*;
#(
  parameter int TEXT_DEPTH      = TEXT_DEPTH_DEF,
  parameter int ROW_LENGTH      = ROW_LENGTH_DEF,
  parameter int VISIBLE_COLUMNS = VISIBLE_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] key_code, [14:8] read_index, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] lcd_byte, [15:8] read_char
  output logic [2:0]  out_tuser,  // [1:0] out_kind, [2] lcd_is_data
  output logic        out_tlast
);

  lle_stat_t stat;
  lle_cmd_t  cmd;

  lle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lle_datapath #(
    .TEXT_DEPTH      (TEXT_DEPTH),
    .ROW_LENGTH      (ROW_LENGTH),
    .VISIBLE_COLUMNS (VISIBLE_COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_kind   (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_user  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule
